### hw/rtl/substring_occurrence_counter_unit_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef SUBSTRING_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH
`define SUBSTRING_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SOC_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define SOC_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/soc_pkg.sv
package soc_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int COUNT_BITS = 32;
  localparam int CELLS = PATTERN_MAX - 1;
  localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
  localparam int PAT_BITS = 64;
  localparam int PLEN_BITS = 4;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic        match_end;
    logic [31:0] match_count;
    logic        text_done;
  } rsp_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic logic [LEN_BITS-1:0] eff_length(
    input logic [PAT_BITS-1:0]  pat,
    input logic [PLEN_BITS-1:0] plen
  );
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] res;
    if (int'(plen) > PATTERN_MAX) begin
      len = LEN_BITS'(PATTERN_MAX);
    end else begin
      len = LEN_BITS'(plen);
    end
    res = len;
    for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
      if (i < int'(len) && pat[8*i +: 8] == 8'd0) begin
        res = LEN_BITS'(i);
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/soc_cell.sv
module soc_cell
  import soc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic [7:0] in_byte,
  input  logic      in_valid,
  input  logic [7:0] pat_byte,
  input  logic      use_cmp,
  output logic [7:0] byte_q,
  output logic      valid_q,
  output logic      ok
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid_q <= 1'b0;
    end else if (ctl.shift) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_q <= in_byte;
    end
  end

  assign ok = !use_cmp || (valid_q && byte_q == pat_byte);

endmodule

### hw/rtl/soc_out_buf.sv
module soc_out_buf
  import soc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  rsp_t in_data,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  logic skid_valid;
  rsp_t skid_data;
  logic out_free;

  assign in_stall = skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

### hw/rtl/substring_occurrence_counter_unit.sv
// Counts overlapping occurrences of a 1 to 8 byte pattern in a byte stream.
// One request carries one text byte: a request may be accepted on every cycle
// while req_stall is low, and its result is registered in the output buffer.
// The pace is set by the row of seven byte cells, which shift the recent text
// and compare it against the pattern in parallel. A two-entry output buffer
// raises req_stall only when both entries hold results that rsp_stall has not
// let go. A zero byte ends the searched text; the request flagged last_byte
// returns the final count and clears the text state. The user must write the
// pattern registers through the cfg port only while idle; it is not enforced.
`include "substring_occurrence_counter_unit_defines.svh"

module substring_occurrence_counter_unit
  import soc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  req_t                      req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output rsp_t                      rsp
);

  logic [PAT_BITS-1:0]   pattern_bytes;
  logic [PLEN_BITS-1:0]  pattern_length;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  terminator;
  logic                  terminator_next;

  logic [LEN_BITS-1:0]   len;
  logic [7:0]            last_pat;
  logic [7:0]            apat [CELLS];
  logic [CELLS-1:0]      use_cmp;
  logic [7:0]            cell_byte [CELLS];
  logic [CELLS-1:0]      cell_valid;
  logic [CELLS-1:0]      cell_ok;
  cell_ctl_t             ctl;
  logic                  acc;
  logic                  active;
  logic                  hit;
  logic [COUNT_BITS-1:0] rsp_count;
  rsp_t                  result;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= PLEN_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data[PAT_BITS-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[PLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign len = eff_length(pattern_bytes, pattern_length);

  always_comb begin
    last_pat = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (j == int'(len) - 1) begin
        last_pat = pattern_bytes[8*j +: 8];
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      apat[i]    = '0;
      use_cmp[i] = (i < int'(len) - 1);
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (j == int'(len) - 2 - i) begin
          apat[i] = pattern_bytes[8*j +: 8];
        end
      end
    end
  end

  assign acc       = req_valid && !req_stall;
  assign active    = acc && !terminator && req.text_byte != 8'd0;
  assign ctl.shift = active;
  assign ctl.clear = acc && req.last_byte;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      soc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .in_byte  (req.text_byte),
        .in_valid (1'b1),
        .pat_byte (apat[k]),
        .use_cmp  (use_cmp[k]),
        .byte_q   (cell_byte[k]),
        .valid_q  (cell_valid[k]),
        .ok       (cell_ok[k])
      );
    end else begin : g_body
      soc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .in_byte  (cell_byte[k-1]),
        .in_valid (cell_valid[k-1]),
        .pat_byte (apat[k]),
        .use_cmp  (use_cmp[k]),
        .byte_q   (cell_byte[k]),
        .valid_q  (cell_valid[k]),
        .ok       (cell_ok[k])
      );
    end
  end

  assign hit = active && len != '0 && req.text_byte == last_pat && &cell_ok;

  always_comb begin
    rsp_count = count;
    if (hit && count != COUNT_MAX) begin
      rsp_count = count + COUNT_BITS'(1);
    end
    count_next      = count;
    terminator_next = terminator;
    if (acc) begin
      count_next = rsp_count;
      if (!terminator && req.text_byte == 8'd0) begin
        terminator_next = 1'b1;
      end
      if (req.last_byte) begin
        count_next      = '0;
        terminator_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      terminator <= 1'b0;
    end else begin
      count      <= count_next;
      terminator <= terminator_next;
    end
  end

  always_comb begin
    result.match_end   = hit;
    result.match_count = 32'(rsp_count);
    result.text_done   = req.last_byte;
  end

  soc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc),
    .in_data   (result),
    .in_stall  (req_stall),
    .out_valid (rsp_valid),
    .out_stall (rsp_stall),
    .out_data  (rsp)
  );

  `SOC_ASSERT_NEXT(a_count_no_drop, acc && !req.last_byte, count >= $past(count))
  `SOC_ASSERT_NEXT(a_term_hold, terminator && !(acc && req.last_byte), terminator)
  `SOC_ASSERT_NOW(a_hit_counted, rsp_valid && rsp.match_end, rsp.match_count != 32'd0)

endmodule

### test/tb_substring_occurrence_counter_unit.sv
module tb_substring_occurrence_counter_unit;
  import soc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 950;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      req_valid;
  logic                      req_stall;
  req_t                      req;
  logic                      rsp_valid;
  logic                      rsp_stall;
  rsp_t                      rsp;

  logic [63:0]  pattern_reg;
  logic [3:0]   length_reg;
  logic [7:0]   history [CELLS];
  int           history_fill;
  logic [31:0]  occurrence_count;
  logic         text_ended;

  rsp_t         pending_counts [$];
  logic [7:0]   text_buf [$];
  logic [7:0]   alphabet [3];

  int           errors = 0;
  int           sent_bytes = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           stall_left = 0;
  stall_style_t stall_style = STALL_NONE;

  substring_occurrence_counter_unit DUT (
    .clk,
    .rst,
    .cfg_write,
    .cfg_index,
    .cfg_data,
    .req_valid,
    .req_stall,
    .req,
    .rsp_valid,
    .rsp_stall,
    .rsp
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_substring_occurrence_counter_unit NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      STALL_NONE:  rsp_stall <= 1'b0;
      STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
      default:     rsp_stall <= ((stall_left % 5) < 2);
    endcase
  end

  function automatic void clear_text();
    for (int i = 0; i < CELLS; i++) history[i] = 8'd0;
    history_fill = 0;
    occurrence_count = '0;
    text_ended = 1'b0;
  endfunction

  function automatic int pattern_span();
    int span;
    int res;
    span = (int'(length_reg) > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
    res = span;
    for (int i = span - 1; i >= 0; i--) begin
      if (pattern_reg[8*i +: 8] == 8'd0) res = i;
    end
    return res;
  endfunction

  function automatic rsp_t predict_count(req_t item);
    rsp_t res;
    int   span;
    logic hit;
    hit = 1'b0;
    if (!text_ended) begin
      if (item.text_byte == 8'd0) begin
        text_ended = 1'b1;
      end else begin
        span = pattern_span();
        if (span > 0 && history_fill >= span - 1) begin
          hit = (pattern_reg[8*(span-1) +: 8] == item.text_byte);
          for (int i = 0; i < span - 1; i++) begin
            if (history[i] != pattern_reg[8*(span-2-i) +: 8]) hit = 1'b0;
          end
        end
        if (hit && occurrence_count != COUNT_MAX) occurrence_count = occurrence_count + 1;
        for (int i = CELLS - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = item.text_byte;
        if (history_fill < CELLS) history_fill = history_fill + 1;
      end
    end
    res.match_end = hit;
    res.match_count = occurrence_count;
    res.text_done = item.last_byte;
    if (item.last_byte) clear_text();
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
    errors++;
  endtask

  initial begin
    rsp_t got;
    rsp_t want;
    logic fire;
    forever begin
      @(posedge clk);
      fire = rsp_valid && !rsp_stall && !rst;
      got = rsp;
      #1;
      if (fire) begin
        if (pending_counts.size() == 0) begin
          report_mismatch("unexpected result", got.match_count, 32'd0);
        end else begin
          want = pending_counts.pop_front();
          if (got.match_end !== want.match_end)
            report_mismatch("match_end", 32'(got.match_end), 32'(want.match_end));
          if (got.match_count !== want.match_count)
            report_mismatch("match_count", got.match_count, want.match_count);
          if (got.text_done !== want.text_done)
            report_mismatch("text_done", 32'(got.text_done), 32'(want.text_done));
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic ends_text);
    req_t item;
    item.text_byte = value;
    item.last_byte = ends_text;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sent_bytes++;
    pending_counts.push_back(predict_count(item));
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t index, input logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (index == REG_PATTERN_BYTES) pattern_reg = value;
    else length_reg = value[3:0];
  endtask

  task automatic test_empty_pattern();
    text_buf = '{8'h01, 8'h80, 8'hFF};
    send_text();
    settle();
    write_reg(REG_PATTERN_BYTES, 64'h41);
    write_reg(REG_PATTERN_LENGTH, 64'h0);
    text_buf = '{8'h41, 8'h41};
    send_text();
  endtask

  task automatic test_overlap();
    settle();
    write_reg(REG_PATTERN_BYTES, 64'h4141);
    write_reg(REG_PATTERN_LENGTH, 64'h2);
    text_buf = '{8'h41, 8'h41, 8'h41, 8'h41};
    send_text();
  endtask

  task automatic test_terminator();
    settle();
    write_reg(REG_PATTERN_BYTES, 64'h41);
    write_reg(REG_PATTERN_LENGTH, 64'h1);
    text_buf = '{8'h41, 8'h00, 8'h41};
    send_text();
    text_buf = '{8'h00};
    send_text();
  endtask

  task automatic test_zero_in_pattern();
    settle();
    write_reg(REG_PATTERN_BYTES, 64'h0000_0000_4200_0041);
    write_reg(REG_PATTERN_LENGTH, 64'h4);
    text_buf = '{8'h41, 8'h42};
    send_text();
  endtask

  task automatic test_long_pattern();
    settle();
    write_reg(REG_PATTERN_BYTES, {64{1'b1}});
    write_reg(REG_PATTERN_LENGTH, 64'hF);
    text_buf = {};
    repeat (9) text_buf.push_back(8'hFF);
    send_text();
  endtask

  task automatic build_text();
    int span;
    int n;
    int pick;
    span = pattern_span();
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    text_buf = {};
    while (text_buf.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 && span > 0) begin
        for (int i = 0; i < span; i++) text_buf.push_back(pattern_reg[8*i +: 8]);
      end else if (pick < 80) begin
        text_buf.push_back(alphabet[$urandom_range(0, 2)]);
      end else if (pick < 98) begin
        text_buf.push_back(8'($urandom_range(1, 255)));
      end else begin
        text_buf.push_back(8'h00);
      end
    end
  endtask

  task automatic test_random_texts();
    int phase;
    int goal;
    logic [63:0] pat;
    logic [3:0]  len;
    phase = 0;
    goal = sent_bytes + RANDOM_BYTES;
    while (sent_bytes < goal) begin
      settle();
      for (int i = 0; i < 3; i++) alphabet[i] = 8'($urandom_range(1, 255));
      for (int i = 0; i < 8; i++) begin
        pat[8*i +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                      : alphabet[$urandom_range(0, 2)];
      end
      if ($urandom_range(0, 7) == 0) pat = {$urandom, $urandom};
      if ($urandom_range(0, 5) == 0) len = 4'($urandom_range(0, 1) ? 0 : $urandom_range(9, 15));
      else len = 4'($urandom_range(1, 8));
      case (phase)
        0: begin
          pat = {64{1'b1}};
          len = 4'd8;
        end
        1: len = 4'd1;
        2: len = 4'd15;
        default: ;
      endcase
      if (phase < 3 || $urandom_range(0, 3) != 0) write_reg(REG_PATTERN_BYTES, pat);
      write_reg(REG_PATTERN_LENGTH, {60'({$urandom, $urandom}), len});
      repeat ($urandom_range(4, 10)) begin
        build_text();
        send_text();
      end
      phase++;
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_write = 1'b0;
    cfg_index = REG_PATTERN_BYTES;
    cfg_data = '0;
    rsp_stall = 1'b0;
    pattern_reg = '0;
    length_reg = 4'd1;
    clear_text();
    for (int i = 0; i < 3; i++) alphabet[i] = 8'h41;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_overlap();
    test_terminator();
    test_zero_in_pattern();
    test_long_pattern();
    test_random_texts();

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_substring_occurrence_counter_unit OK");
    end else begin
      $display("tb_substring_occurrence_counter_unit NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/soc_pkg.sv
hw/rtl/soc_cell.sv
hw/rtl/soc_out_buf.sv
hw/rtl/substring_occurrence_counter_unit.sv
test/tb_substring_occurrence_counter_unit.sv
